[design/far_pkg.sv]
// ----------------------------------------------------------------------------
// far_pkg: shared types and constants of the reduced fraction adder.
// Holds the output field widths, the default operand width, the work width,
// the sequencer states and the divider request and answer types.
// ----------------------------------------------------------------------------
package far_pkg;

  localparam int OperandWidthDefault = 16;
  localparam int NumOutWidth = 33;
  localparam int DenOutWidth = 32;
  // Internal arithmetic width. The common denominator needs two operand widths,
  // and a scaled sum needs one more bit than a scaled numerator.
  localparam int WorkWidth = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD1,
    ST_LCM_DIV,
    ST_LCM_MUL,
    ST_Q1,
    ST_T1,
    ST_Q2,
    ST_T2,
    ST_SUM,
    ST_GCD2,
    ST_RED_NUM,
    ST_RED_DEN,
    ST_DONE
  } state_t;

  // Request to the shared divider and its answer.
  typedef struct packed {
    logic                 start;
    logic [WorkWidth-1:0] dividend;
    logic [WorkWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [WorkWidth-1:0] quotient;
    logic [WorkWidth-1:0] remainder;
  } div_rsp_t;

endpackage

[design/fraction_adder_reduced_core.sv]
// ----------------------------------------------------------------------------
// fraction_adder_reduced_core: adds two fractions and reduces the sum.
//
//   channel  | signals                                         | direction
//   request  | start, first_/second_numerator/denominator; busy is out | in
//   result   | done, sum_numerator, sum_denominator, status    | out
//
// Every remainder, quotient and reduction step goes through one shared
// divider, and the two Euclid loops take one division per iteration (up to
// about 25 for the denominators and about 47 for the reduction).
// A zero denominator skips the arithmetic and answers with status set.
// busy is high from the accepted request and is low again by the done strobe.
// Reset is synchronous and returns the sequencer to idle.
// Results appear for one cycle on done; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module fraction_adder_reduced_core #(
  parameter int OPERAND_WIDTH = far_pkg::OperandWidthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [OPERAND_WIDTH-1:0]     first_numerator,
  input  logic        [OPERAND_WIDTH-1:0]     first_denominator,
  input  logic signed [OPERAND_WIDTH-1:0]     second_numerator,
  input  logic        [OPERAND_WIDTH-1:0]     second_denominator,
  output logic                                done,
  output logic signed [far_pkg::NumOutWidth-1:0] sum_numerator,
  output logic        [far_pkg::DenOutWidth-1:0] sum_denominator,
  output logic                                status
);

  localparam int W = far_pkg::WorkWidth;
  localparam int OW = OPERAND_WIDTH;
  // Every product has factors of at most one operand width.
  localparam int MW = W / 2;

  far_pkg::state_t state, state_next;
  far_pkg::div_req_t req;
  far_pkg::div_rsp_t rsp;

  logic [W-1:0] d1, d2, mag1, mag2;
  logic         neg1, neg2;
  logic [W-1:0] ga, gb;     // Euclid operands
  logic [W-1:0] lcm, t1, t2, smag;
  logic         sneg;
  logic         err;
  logic         issued;     // a division request is in flight

  logic [MW-1:0] mul_a, mul_b;
  logic [W-1:0]  mul_p;

  assign mul_p = mul_a * mul_b;

  far_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= far_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Next state, divider requests and multiplier operands.
  always_comb begin
    state_next   = state;
    req.start    = 1'b0;
    req.dividend = ga;
    req.divisor  = gb;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      far_pkg::ST_IDLE: begin
        if (start) state_next = far_pkg::ST_GCD1;
      end
      far_pkg::ST_GCD1, far_pkg::ST_GCD2: begin
        if (err) state_next = far_pkg::ST_DONE;
        else if (!issued && gb == '0) begin
          state_next = (state == far_pkg::ST_GCD1) ? far_pkg::ST_LCM_DIV
                                                   : far_pkg::ST_RED_NUM;
        end else begin
          req.start = !issued;
        end
      end
      far_pkg::ST_LCM_DIV: begin
        req.dividend = d1;
        req.divisor  = ga;
        req.start    = !issued;
        if (rsp.done) state_next = far_pkg::ST_LCM_MUL;
      end
      far_pkg::ST_LCM_MUL: begin
        state_next = far_pkg::ST_Q1;
      end
      far_pkg::ST_Q1, far_pkg::ST_Q2: begin
        req.dividend = lcm;
        req.divisor  = (state == far_pkg::ST_Q1) ? d1 : d2;
        req.start    = !issued;
        if (rsp.done) state_next = (state == far_pkg::ST_Q1) ? far_pkg::ST_T1
                                                           : far_pkg::ST_T2;
      end
      far_pkg::ST_T1: begin
        mul_a = MW'(mag1); mul_b = MW'(t1);
        state_next = far_pkg::ST_Q2;
      end
      far_pkg::ST_T2: begin
        mul_a = MW'(mag2); mul_b = MW'(t2);
        state_next = far_pkg::ST_SUM;
      end
      far_pkg::ST_SUM: begin
        state_next = far_pkg::ST_GCD2;
      end
      far_pkg::ST_RED_NUM: begin
        req.dividend = smag;
        req.divisor  = ga;
        req.start    = !issued;
        if (rsp.done) state_next = far_pkg::ST_RED_DEN;
      end
      far_pkg::ST_RED_DEN: begin
        req.dividend = lcm;
        req.divisor  = ga;
        req.start    = !issued;
        if (rsp.done) state_next = far_pkg::ST_DONE;
      end
      far_pkg::ST_DONE: begin
        state_next = far_pkg::ST_IDLE;
      end
      default: state_next = far_pkg::ST_IDLE;
    endcase
    if (state == far_pkg::ST_LCM_MUL) begin
      mul_a = MW'(t1); mul_b = MW'(d2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= (state == far_pkg::ST_DONE);
      if (req.start) issued <= 1'b1;
      else if (rsp.done) issued <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      far_pkg::ST_IDLE: begin
        if (start) begin
          d1   <= W'(first_denominator);
          d2   <= W'(second_denominator);
          ga   <= W'(first_denominator);
          gb   <= W'(second_denominator);
          neg1 <= first_numerator[OW-1];
          neg2 <= second_numerator[OW-1];
          mag1 <= W'($unsigned(first_numerator[OW-1] ? OW'(-first_numerator)
                                                     : first_numerator));
          mag2 <= W'($unsigned(second_numerator[OW-1] ? OW'(-second_numerator)
                                                      : second_numerator));
          err  <= (first_denominator == '0) || (second_denominator == '0);
        end
      end
      far_pkg::ST_GCD1, far_pkg::ST_GCD2: begin
        if (rsp.done) begin
          ga <= gb;
          gb <= rsp.remainder;
        end
      end
      far_pkg::ST_LCM_DIV: if (rsp.done) t1 <= rsp.quotient;
      far_pkg::ST_LCM_MUL: lcm <= mul_p;
      far_pkg::ST_Q1: if (rsp.done) t1 <= rsp.quotient;
      far_pkg::ST_Q2: if (rsp.done) t2 <= rsp.quotient;
      far_pkg::ST_T1: t1 <= mul_p;
      far_pkg::ST_T2: t2 <= mul_p;
      far_pkg::ST_SUM: begin
        if (neg1 == neg2) begin
          smag <= t1 + t2; sneg <= neg1;
          ga   <= t1 + t2;
        end else if (t1 >= t2) begin
          smag <= t1 - t2; sneg <= neg1;
          ga   <= t1 - t2;
        end else begin
          smag <= t2 - t1; sneg <= neg2;
          ga   <= t2 - t1;
        end
        gb <= lcm;
      end
      far_pkg::ST_RED_NUM: if (rsp.done) smag <= rsp.quotient;
      far_pkg::ST_RED_DEN: if (rsp.done) lcm <= rsp.quotient;
      far_pkg::ST_DONE: begin
        if (smag == '0) sneg <= 1'b0;
      end
      default: ;
    endcase
  end

  // A zero sum divides lcm by itself, which gives the 0/1 form directly.
  assign busy            = (state != far_pkg::ST_IDLE);
  assign status          = err;
  assign sum_numerator   = err ? '0 : (sneg ? -smag[far_pkg::NumOutWidth-1:0]
                                            : smag[far_pkg::NumOutWidth-1:0]);
  assign sum_denominator = err ? '0 : lcm[far_pkg::DenOutWidth-1:0];

  a_busy_on_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy did not rise after request");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

endmodule

[design/far_divider.sv]
// ----------------------------------------------------------------------------
// far_divider: shared restoring divider.
// Produces one quotient bit per cycle. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module far_divider (
  input  logic               clk,
  input  logic               rst,
  input  far_pkg::div_req_t  req,
  output far_pkg::div_rsp_t  rsp
);

  localparam int W = far_pkg::WorkWidth;
  localparam int CW = $clog2(W + 1);

  logic         busy;
  logic [CW-1:0] count;
  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic [W-1:0] dvs;
  logic         done;

  logic [W:0]   trial;
  logic [W:0]   shifted;

  always_comb begin
    shifted = {rem, quo[W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= CW'(W);
        quo   <= req.dividend;
        rem   <= '0;
        dvs   <= req.divisor;
      end else if (busy) begin
        // Trial subtract; the borrow bit decides the quotient bit.
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= shifted[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[tb/fraction_adder_reduced_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_adder_reduced_core_tb: self-checking bench of the fraction adder.
// A table of directed requests comes first, then random requests under
// several sender idling phases. Each expected result is typed in or predicted
// from the two fractions and compared field by field with the strobed result.
// ----------------------------------------------------------------------------
module fraction_adder_reduced_core_tb;

  localparam int OpW = far_pkg::OperandWidthDefault;
  localparam int NumOutWidth = far_pkg::NumOutWidth;
  localparam int DenOutWidth = far_pkg::DenOutWidth;
  localparam int WatchdogLimit = 200000;

  typedef struct {
    logic signed [NumOutWidth-1:0] num;
    logic [DenOutWidth-1:0] den;
    logic stat;
  } sum_t;

  typedef struct {
    logic [OpW-1:0] n1, d1, n2, d2;
    bit typed;
    sum_t res;
  } row_t;

  logic clk, rst, start, busy, done, status;
  logic signed [OpW-1:0] first_numerator, second_numerator;
  logic [OpW-1:0] first_denominator, second_denominator;
  logic signed [NumOutWidth-1:0] sum_numerator;
  logic [DenOutWidth-1:0] sum_denominator;

  sum_t pending_sums[$];
  int errors = 0;
  int idle_cycles = 0;
  int idle_pct = 0;
  bit stim_done = 0;

  fraction_adder_reduced_core dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic sum_t reduced_sum(logic [OpW-1:0] n1, d1, n2, d2);
    sum_t s;
    longint unsigned m1, m2, g, lcm, t1, t2, smag;
    bit ng1, ng2, sneg;
    if (d1 == 0 || d2 == 0) begin
      s.num = '0; s.den = '0; s.stat = 1'b1;
      return s;
    end
    ng1 = n1[OpW-1];
    ng2 = n2[OpW-1];
    m1 = ng1 ? {48'd0, -n1} : {48'd0, n1};
    m2 = ng2 ? {48'd0, -n2} : {48'd0, n2};
    g = euclid_gcd(d1, d2);
    lcm = (d1 / g) * d2;
    t1 = m1 * (lcm / d1);
    t2 = m2 * (lcm / d2);
    if (ng1 == ng2) begin
      smag = t1 + t2; sneg = ng1;
    end else if (t1 >= t2) begin
      smag = t1 - t2; sneg = ng1;
    end else begin
      smag = t2 - t1; sneg = ng2;
    end
    if (smag == 0) sneg = 0;
    g = euclid_gcd(smag, lcm);
    if (g == 0) g = 1;
    smag = smag / g;
    lcm = lcm / g;
    s.num = sneg ? NumOutWidth'(-smag) : NumOutWidth'(smag);
    s.den = DenOutWidth'(lcm);
    s.stat = 1'b0;
    return s;
  endfunction

  // Drives one request and waits until the block takes it.
  task automatic send_request(row_t r);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    first_numerator <= r.n1;
    first_denominator <= r.d1;
    second_numerator <= r.n2;
    second_denominator <= r.d2;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_sums.push_back(r.typed ? r.res : reduced_sum(r.n1, r.d1, r.n2, r.d2));
    @(negedge clk);
    start <= 1'b0;
    // Let start be seen low before the next request.
    @(negedge clk);
  endtask

  function automatic logic [OpW-1:0] rand_den();
    case ($urandom_range(3))
      0: return OpW'($urandom_range(1, 12));
      1: return OpW'($urandom_range(1, 255));
      2: return 16'hFFFF - OpW'($urandom_range(0, 40));
      default: return ($urandom_range(31) == 0) ? '0 : OpW'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    sum_t e;
    if (!rst && done) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: result with no request waiting: %0d/%0d st %0d", $time,
                 sum_numerator, sum_denominator, status);
        errors++;
      end else begin
        e = pending_sums.pop_front();
        if (sum_numerator !== e.num || sum_denominator !== e.den || status !== e.stat) begin
          $display("%0t: expected %0d/%0d st %0d, actual %0d/%0d st %0d", $time,
                   e.num, e.den, e.stat, sum_numerator, sum_denominator, status);
          errors++;
        end
      end
    end
  end

  // Counts cycles without any request or result moving.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[fraction_adder_reduced_core] ERROR");
      $finish;
    end
  end

  initial begin
    row_t dir[$];
    row_t r;
    int waited;
    rst = 1; start = 0;
    first_numerator = '0; first_denominator = '0;
    second_numerator = '0; second_denominator = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed rows: zero denominators and simple sums are typed in.
    dir.push_back('{16'sd1, 16'd0, 16'sd1, 16'd1, 1, '{33'sd0, 32'd0, 1'b1}});
    dir.push_back('{16'sd1, 16'd1, 16'sd1, 16'd0, 1, '{33'sd0, 32'd0, 1'b1}});
    dir.push_back('{16'sd0, 16'd0, 16'sd0, 16'd0, 1, '{33'sd0, 32'd0, 1'b1}});
    dir.push_back('{16'sd1, 16'd2, 16'sd1, 16'd2, 1, '{33'sd1, 32'd1, 1'b0}});
    dir.push_back('{16'sd1, 16'd2, -16'sd1, 16'd2, 1, '{33'sd0, 32'd1, 1'b0}});
    dir.push_back('{16'sd0, 16'd5, 16'sd0, 16'd7, 1, '{33'sd0, 32'd1, 1'b0}});
    dir.push_back('{16'sd1, 16'd3, 16'sd1, 16'd6, 1, '{33'sd1, 32'd2, 1'b0}});
    dir.push_back('{-16'sd1, 16'd3, -16'sd1, 16'd6, 1, '{-33'sd1, 32'd2, 1'b0}});
    dir.push_back('{16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFE, 0, '{0, 0, 0}});
    dir.push_back('{16'h8000, 16'hFFFF, 16'h8000, 16'hFFFE, 0, '{0, 0, 0}});
    dir.push_back('{16'h8000, 16'd1, 16'h8000, 16'd1, 0, '{0, 0, 0}});
    dir.push_back('{16'h7FFF, 16'd1, 16'h8000, 16'd1, 0, '{0, 0, 0}});
    dir.push_back('{16'h8000, 16'hFFFF, 16'h7FFF, 16'h0001, 0, '{0, 0, 0}});
    dir.push_back('{16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF, 0, '{0, 0, 0}});
    dir.push_back('{16'h1234, 16'h5555, 16'hEDCC, 16'hAAAA, 0, '{0, 0, 0}});
    dir.push_back('{16'h0006, 16'h0009, 16'h0003, 16'h0012, 0, '{0, 0, 0}});
    foreach (dir[i]) send_request(dir[i]);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 75 : (ph == 3) ? 28 : 0;
      for (int k = 0; k < 75; k++) begin
        r.n1 = ($urandom_range(3) == 0) ? OpW'($urandom_range(0, 20) - 10) : OpW'($urandom);
        r.n2 = ($urandom_range(3) == 0) ? OpW'($urandom_range(0, 20) - 10) : OpW'($urandom);
        r.d1 = rand_den();
        r.d2 = ($urandom_range(4) == 0) ? r.d1 : rand_den();
        r.typed = 0;
        send_request(r);
      end
    end

    waited = 0;
    while (pending_sums.size() != 0 && waited < WatchdogLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("[fraction_adder_reduced_core] OK");
    end else begin
      $display("[fraction_adder_reduced_core] ERROR");
    end
    $finish;
  end
endmodule
